// ===== rtl/m2d_pkg.sv =====
// Package for the masked 2x2 downsampler: sample constants, lane control
// struct, register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package m2d_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int NUM_CH      = 4;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;
  localparam int PAIR_W      = SAMPLE_BITS + 1;   // sum of two samples
  localparam int SUM_W       = SAMPLE_BITS + 2;   // sum of four samples
  localparam int HALF_SHIFT  = 29 - SAMPLE_BITS;
  // 3 * RECIP3 = 2^19 + 1, exact floor(y/3) for y < 2^19
  localparam logic [17:0] RECIP3 = 18'd174763;
  // ceil(SMAX^2 / 10000)
  localparam logic [33:0] NM_THR = 34'd429484;

  localparam int SQ_IN_W   = 62;
  localparam int ROOT_W    = 31;
  localparam int NUM_W     = 48;
  localparam int QUO_BITS  = 17;
  localparam int QBIT_W    = 5;

  typedef enum logic [2:0] {
    REG_OUT_WIDTH  = 3'd0,
    REG_OUT_HEIGHT = 3'd1,
    REG_CHAN_COUNT = 3'd2,
    REG_CHAN_EN    = 3'd3,
    REG_NORMAL_MAP = 3'd4,
    REG_ALPHA_UNW  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              avg_en;
    logic              sq_en;
    logic              prep_en;
    logic              div_en;
    logic [QBIT_W-1:0] div_bit;
    logic              div_last;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/m2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module m2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/m2d_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on m2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module m2d_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [m2d_pkg::SQ_IN_W-1:0] x,
  output logic      [m2d_pkg::ROOT_W-1:0]  root,
  output logic                             done
);

  localparam int RW = m2d_pkg::ROOT_W + 2;

  logic [m2d_pkg::SQ_IN_W-1:0] x_r;
  logic [RW-1:0]               rem_r, rem_nxt, remsh, trial;
  logic [m2d_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [4:0]                  cnt_r;
  logic                        busy_r, done_r, ge;

  always_comb begin
    remsh    = {rem_r[RW-3:0], x_r[m2d_pkg::SQ_IN_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    ge       = (remsh >= trial);
    rem_nxt  = ge ? (remsh - trial) : remsh;
    root_nxt = {root_r[m2d_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(m2d_pkg::SQ_IN_W / 2);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[m2d_pkg::SQ_IN_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== rtl/m2d_lane.sv =====
// One channel lane: weighted average, squared component, and the
// renormalizing divide (restoring, one quotient bit per cycle).
// Depends on m2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module m2d_lane (
  input  wire logic                            clk,
  input  wire m2d_pkg::lane_ctrl_t             ctrl,
  input  wire logic [m2d_pkg::SUM_W-1:0]       sum,
  input  wire logic [2:0]                      cnt,
  input  wire logic                            act,
  input  wire logic                            alpha,
  input  wire logic [m2d_pkg::ROOT_W-1:0]      root,
  output logic      [m2d_pkg::SAMPLE_BITS-1:0] o,
  output logic      [31:0]                     sq
);

  localparam int SW = m2d_pkg::SUM_W;

  logic [m2d_pkg::SAMPLE_BITS-1:0] o_r, avg;
  logic signed [SW-1:0]            comp, comp_r;
  logic signed [2*SW-1:0]          sqf;
  logic [31:0]                     sq_r;
  logic [m2d_pkg::NUM_W-1:0]       rem_r, num, shifted;
  logic [31:0]                     den_r, t;
  logic signed [33:0]              t34;
  logic [m2d_pkg::QUO_BITS-1:0]    quo_r, quo_nxt;
  logic [SW:0]                     inc1, inc2;
  logic [36:0]                     prod;
  logic [SW-1:0]                   v;
  logic                            ge;

  // average: (2S + n) / (2n), n in 1..4, clamped to SMAX; the alpha lane uses (S + 2) / 4
  always_comb begin
    inc1 = {1'b0, sum} + (SW+1)'(1);
    inc2 = {1'b0, sum} + (SW+1)'(2);
    prod = 37'(inc1) * 37'(m2d_pkg::RECIP3);
    unique case (cnt)
      3'd1:    v = sum;
      3'd2:    v = inc1[SW:1];
      3'd3:    v = prod[36:19];
      3'd4:    v = SW'(inc2[SW:2]);
      default: v = '0;
    endcase
    if (alpha) begin
      avg = inc2[SW-1:2];
    end else if (v > SW'(m2d_pkg::SMAX)) begin
      avg = m2d_pkg::SMAX;
    end else begin
      avg = v[m2d_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    comp = signed'({1'b0, o_r, 1'b0}) - signed'(SW'(m2d_pkg::SMAX));
    sqf  = comp * comp;
    t34  = signed'({3'b000, root}) + (34'(comp_r) <<< m2d_pkg::HALF_SHIFT);
    t    = t34[31:0];
    num  = {t, 16'h0000} - {16'h0000, t} + {17'h00000, root};
    shifted = {16'h0000, den_r} << ctrl.div_bit;
    ge      = (rem_r >= shifted);
    quo_nxt = quo_r;
    quo_nxt[ctrl.div_bit] = ge;
  end

  always_ff @(posedge clk) begin
    if (ctrl.avg_en) begin
      o_r <= act ? avg : '0;
    end else if (ctrl.div_en && ctrl.div_last && act) begin
      o_r <= quo_nxt[m2d_pkg::SAMPLE_BITS-1:0];
    end
    if (ctrl.sq_en) begin
      comp_r <= comp;
      sq_r   <= sqf[31:0];
    end
    if (ctrl.prep_en) begin
      rem_r <= num;
      den_r <= {root, 1'b0};
      quo_r <= '0;
    end else if (ctrl.div_en) begin
      if (ge) begin
        rem_r <= rem_r - shifted;
      end
      quo_r <= quo_nxt;
    end
  end

  assign o  = o_r;
  assign sq = sq_r;

endmodule
`default_nettype wire

// ===== rtl/masked_2x2_downsample.sv =====
// Masked 2x2 downsampler top: pair register, line store, four channel lanes,
// length merge and square root unit. Depends on m2d_pkg, m2d_ram, m2d_lane, m2d_sqrt.
// Pixels that give no result are only stored. A result pixel goes through the
// AVG and OUT states to the output register; in normal-map mode a covered block
// also passes SQ and SUM and, unless the vector is near zero, a 31-step square
// root and a 17-step divide. One pixel in flight at a time.
// Reset (synchronous, rst_n low) clears position, pair register and control
// state and sets the config registers to defaults; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module masked_2x2_downsample #(
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_chan0,
  input  wire logic [15:0] in_chan1,
  input  wire logic [15:0] in_chan2,
  input  wire logic [15:0] in_chan3,
  input  wire logic        in_covered,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] out_chan0,
  output logic      [15:0] out_chan1,
  output logic      [15:0] out_chan2,
  output logic      [15:0] out_chan3,
  output logic             out_covered,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int SB  = m2d_pkg::SAMPLE_BITS;
  localparam int NC  = m2d_pkg::NUM_CH;
  localparam int PW  = m2d_pkg::PAIR_W;
  localparam int AW  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int CW  = AW + 2;
  localparam int RW  = 12;
  localparam int MW  = NC * PW + 2;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_AVG  = 8'b0000_0010,
    ST_SQ   = 8'b0000_0100,
    ST_SUM  = 8'b0000_1000,
    ST_SQRT = 8'b0001_0000,
    ST_PREP = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [10:0] ow_r, oh_r;
  logic [2:0]  cc_r;
  logic [3:0]  en_r;
  logic        nm_r, au_r;

  logic [CW-1:0] col_r, col_nxt, c0, c1, w2;
  logic [RW-1:0] row_r, row_nxt, r0, r1, r2, h2;
  logic [AW:0]   w_eff;
  logic [10:0]   h_eff;
  logic [2:0]    n_eff;

  logic [SB-1:0] chan_in [NC];
  logic [SB-1:0] left_r  [NC];
  logic          left_cov_r;
  logic [PW-1:0] ps      [NC];
  logic [PW-1:0] ps_r    [NC];
  logic [1:0]    pc, pc_r;
  logic [2:0]    cnt, cnt_r;
  logic [NC-1:0] act, act_r, alpha_ln;

  logic          accept, odd_col, odd_row;
  logic          ram_we, ram_re;
  logic [MW-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0] pair;

  m2d_pkg::lane_ctrl_t lctl;
  logic [m2d_pkg::QBIT_W-1:0] qbit_r;
  logic [m2d_pkg::SUM_W-1:0]  lsum [NC];
  logic [SB-1:0]              lo   [NC];
  logic [31:0]                lsq  [NC];
  logic [33:0]                qsum;
  logic [m2d_pkg::ROOT_W-1:0] root;
  logic                       sq_start, sq_done;

  logic          out_valid_r, out_cov_r, out_load;
  logic [SB-1:0] out_r [NC];

  assign chan_in[0] = in_chan0;
  assign chan_in[1] = in_chan1;
  assign chan_in[2] = in_chan2;
  assign chan_in[3] = in_chan3;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;

  // clamped geometry
  always_comb begin
    if (ow_r == 11'd0) begin
      w_eff = (AW+1)'(1);
    end else if (32'(ow_r) > 32'(MAX_OUT_WIDTH)) begin
      w_eff = (AW+1)'(MAX_OUT_WIDTH);
    end else begin
      w_eff = (AW+1)'(ow_r);
    end
    if (oh_r == 11'd0) begin
      h_eff = 11'd1;
    end else if (oh_r > 11'd1024) begin
      h_eff = 11'd1024;
    end else begin
      h_eff = oh_r;
    end
    if (cc_r == 3'd0) begin
      n_eff = 3'd1;
    end else if (cc_r > 3'(NC)) begin
      n_eff = 3'(NC);
    end else begin
      n_eff = cc_r;
    end
    w2 = {w_eff, 1'b0};
    h2 = {h_eff, 1'b0};
  end

  // position: stale position wraps first, then advance after the pixel
  always_comb begin
    c0 = (col_r >= w2) ? '0 : col_r;
    r1 = (col_r >= w2) ? (row_r + RW'(1)) : row_r;
    r0 = (r1 >= h2) ? '0 : r1;
    c1 = c0 + CW'(1);
    r2 = r0 + RW'(1);
    col_nxt = c0;
    row_nxt = r0;
    if (accept) begin
      if (c1 >= w2) begin
        col_nxt = '0;
        row_nxt = (r2 >= h2) ? '0 : r2;
      end else begin
        col_nxt = c1;
      end
    end else begin
      col_nxt = col_r;
      row_nxt = row_r;
    end
    odd_col = c0[0];
    odd_row = r0[0];
    pair    = c0[AW:1];
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      ps[c] = {1'b0, left_r[c]} + {1'b0, chan_in[c]};
    end
    pc = {1'b0, left_cov_r} + {1'b0, in_covered};
    ram_we = accept && odd_col && !odd_row;
    ram_re = accept && odd_col && odd_row;
    ram_wdata[MW-1 -: 2] = pc;
    for (int c = 0; c < NC; c++) begin
      ram_wdata[c*PW +: PW] = ps[c];
    end
  end

  m2d_ram #(.WIDTH(MW), .DEPTH(MAX_OUT_WIDTH)) u_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (pair),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (pair),
    .rd_data (ram_rdata)
  );

  always_comb begin
    cnt = {1'b0, pc_r} + {1'b0, ram_rdata[MW-1 -: 2]};
    for (int c = 0; c < NC; c++) begin
      lsum[c]     = {1'b0, ps_r[c]} + {1'b0, ram_rdata[c*PW +: PW]};
      act[c]      = (3'(c) < n_eff) && en_r[c] && (cnt != 3'd0);
      alpha_ln[c] = au_r && (3'(c) == n_eff - 3'd1);
    end
  end

  always_comb begin
    lctl          = '0;
    lctl.avg_en   = (state_r == ST_AVG);
    lctl.sq_en    = (state_r == ST_SQ);
    lctl.prep_en  = (state_r == ST_PREP);
    lctl.div_en   = (state_r == ST_DIV);
    lctl.div_bit  = qbit_r;
    lctl.div_last = (qbit_r == '0);
  end

  for (genvar g = 0; g < NC; g++) begin : g_lane
    m2d_lane u_lane (
      .clk   (clk),
      .ctrl  (lctl),
      .sum   (lsum[g]),
      .cnt   (cnt),
      .act   ((state_r == ST_AVG) ? act[g] : act_r[g]),
      .alpha (alpha_ln[g]),
      .root  (root),
      .o     (lo[g]),
      .sq    (lsq[g])
    );
  end

  // merge: squared length over active lanes
  always_comb begin
    qsum = '0;
    for (int c = 0; c < NC; c++) begin
      if (act_r[c]) begin
        qsum = qsum + 34'(lsq[c]);
      end
    end
  end

  assign sq_start = (state_r == ST_SUM) && (qsum >= m2d_pkg::NM_THR);

  m2d_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     ({2'b00, qsum, 26'h0}),
    .root  (root),
    .done  (sq_done)
  );

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (ram_re) state_nxt = ST_AVG;
      ST_AVG:  state_nxt = (nm_r && cnt != 3'd0) ? ST_SQ : ST_OUT;
      ST_SQ:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = sq_start ? ST_SQRT : ST_OUT;
      ST_SQRT: if (sq_done) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (qbit_r == '0) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      left_cov_r  <= 1'b0;
      out_valid_r <= 1'b0;
      qbit_r      <= '0;
      ow_r        <= 11'd1;
      oh_r        <= 11'd1;
      cc_r        <= 3'd4;
      en_r        <= 4'hF;
      nm_r        <= 1'b0;
      au_r        <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        left_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (accept && !odd_col) begin
        left_cov_r <= in_covered;
        for (int c = 0; c < NC; c++) begin
          left_r[c] <= chan_in[c];
        end
      end
      if (state_r == ST_PREP) begin
        qbit_r <= m2d_pkg::QBIT_W'(m2d_pkg::QUO_BITS - 1);
      end else if (state_r == ST_DIV) begin
        qbit_r <= qbit_r - m2d_pkg::QBIT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          m2d_pkg::REG_OUT_WIDTH:  ow_r <= cfg_data;
          m2d_pkg::REG_OUT_HEIGHT: oh_r <= cfg_data;
          m2d_pkg::REG_CHAN_COUNT: cc_r <= cfg_data[2:0];
          m2d_pkg::REG_CHAN_EN:    en_r <= cfg_data[3:0];
          m2d_pkg::REG_NORMAL_MAP: nm_r <= cfg_data[0];
          m2d_pkg::REG_ALPHA_UNW:  au_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      pc_r <= pc;
      for (int c = 0; c < NC; c++) begin
        ps_r[c] <= ps[c];
      end
    end
    if (state_r == ST_AVG) begin
      cnt_r <= cnt;
      act_r <= act;
    end
    if (out_load) begin
      out_cov_r <= (cnt_r != 3'd0);
      for (int c = 0; c < NC; c++) begin
        out_r[c] <= lo[c];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_covered = out_cov_r;
  assign out_chan0   = out_r[0];
  assign out_chan1   = out_r[1];
  assign out_chan2   = out_r[2];
  assign out_chan3   = out_r[3];

endmodule
`default_nettype wire

// ===== rtl/m2d_checker.sv =====
// Port-level checks for masked_2x2_downsample, bound to the top level.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module m2d_sva (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        in_stall,
  input wire logic [15:0] out_chan0,
  input wire logic [15:0] out_chan1,
  input wire logic [15:0] out_chan2,
  input wire logic [15:0] out_chan3,
  input wire logic        out_covered
);

  // held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chan0) && $stable(out_chan1)
      && $stable(out_chan2) && $stable(out_chan3) && $stable(out_covered))
    else $error("stalled result changed");

  // uncovered block gives all-zero channels
  a_uncov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_covered |-> out_chan0 == 16'h0 && out_chan1 == 16'h0
      && out_chan2 == 16'h0 && out_chan3 == 16'h0)
    else $error("uncovered block with nonzero channel");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result is only raised while the input side was busy
  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule

bind masked_2x2_downsample m2d_sva u_m2d_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .in_stall    (in_stall),
  .out_chan0   (out_chan0),
  .out_chan1   (out_chan1),
  .out_chan2   (out_chan2),
  .out_chan3   (out_chan3),
  .out_covered (out_covered)
);
`default_nettype wire
